/* hw/rtl/cubic_bezier_flattener_unit_macros.svh */
// assertion macros for the cubic bezier flattener
// used by the top level only, no other dependencies
`ifndef CUBIC_BEZIER_FLATTENER_UNIT_MACROS_SVH
`define CUBIC_BEZIER_FLATTENER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BCF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcf assertion failed");
`define BCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcf assertion failed");
`else
`define BCF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BCF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/bcf_pkg.sv */
// shared types and constants of the cubic bezier flattener
// no dependencies
`default_nettype none
package bcf_pkg;
   localparam int TOL_BITS     = 4;
   localparam int STROKE_BITS  = 8;
   localparam int PAINT_BITS   = 16;
   localparam int OPACITY_BITS = 8;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;

   localparam logic [2:0] REG_FLAT_TOL    = 3'd0;
   localparam logic [2:0] REG_CLIP_LEFT   = 3'd1;
   localparam logic [2:0] REG_CLIP_TOP    = 3'd2;
   localparam logic [2:0] REG_CLIP_RIGHT  = 3'd3;
   localparam logic [2:0] REG_CLIP_BOTTOM = 3'd4;

   localparam int TOL_RESET    = 1;
   localparam int CLIP_LO_RESET = 0;
   localparam int CLIP_HI_RESET = 4095;

   typedef struct packed {
      logic done;
      logic flat;
   } bcf_flat_res_type;
endpackage
`default_nettype wire

/* hw/rtl/bcf_req_if.sv */
// curve input channel: valid, ready and the curve payload
// no dependencies
`default_nettype none
interface bcf_req_if #(parameter int COORD_BITS = 13);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] start_x, start_y, ctrl_a_x, ctrl_a_y;
   logic signed [COORD_BITS-1:0] ctrl_b_x, ctrl_b_y, finish_x, finish_y;
   logic [7:0]  stroke;
   logic [15:0] paint;
   logic [7:0]  opacity;
   modport source (output valid, start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y,
                   finish_x, finish_y, stroke, paint, opacity, input ready);
   modport sink (input valid, start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y,
                 finish_x, finish_y, stroke, paint, opacity, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bcf_rsp_if.sv */
// line segment result channel: valid, ready and the segment payload
// no dependencies
`default_nettype none
interface bcf_rsp_if #(parameter int COORD_BITS = 13);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
   logic [7:0]  seg_stroke;
   logic [15:0] seg_paint;
   logic [7:0]  seg_opacity;
   logic        high_quality;
   logic        last_segment;
   modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, seg_stroke,
                   seg_paint, seg_opacity, high_quality, last_segment, input ready);
   modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, seg_stroke,
                 seg_paint, seg_opacity, high_quality, last_segment, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bcf_mul.sv */
// shared signed multiplier with registered product
// no dependencies
`default_nettype none
module bcf_mul #(
   parameter int W = 29
) (
   input  wire logic                  clock,
   input  wire logic signed [W-1:0]   op_a,
   input  wire logic signed [W-1:0]   op_b,
   output logic signed [2*W-1:0]      prod_ff
);
   logic signed [2*W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

/* hw/rtl/bcf_flat.sv */
// flatness test sequencer: nine products through one shared multiplier
// depends on bcf_pkg and bcf_mul
`default_nettype none
module bcf_flat
   import bcf_pkg::*;
#(
   parameter int COORD_BITS = 13
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [TOL_BITS-1:0]         tol,
   input  wire logic [7:0][COORD_BITS-1:0]  pts,
   output bcf_flat_res_type                 res_ff
);
   localparam int D  = COORD_BITS + 1;
   localparam int MW = 2 * D + 1;
   localparam int PW = 2 * MW;

   typedef enum logic [3:0] {
      ST_AX_DY, ST_AY_DX, ST_BX_DY, ST_BY_DX, ST_DX_DX, ST_DY_DY,
      ST_TOL, ST_THR, ST_MC, ST_CMP, ST_DONE
   } step_type;

   logic            busy_ff;
   step_type        step_ff;
   logic signed [D-1:0]  dx_ff, dy_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [MW-1:0] t_ff, mc_ff, len2_ff;
   logic signed [PW-1:0] thr_ff;
   logic signed [MW-1:0] op_a, op_b;
   logic signed [PW-1:0] prod_ff;
   logic signed [MW-1:0] prod_lo, diff, diff_abs;

   function automatic logic signed [D-1:0] sub_pt(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
      return $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
   endfunction

   function automatic logic signed [MW-1:0] ext(input logic signed [D-1:0] v);
      return {{(MW-D){v[D-1]}}, v};
   endfunction

   bcf_mul #(.W(MW)) u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   assign prod_lo  = prod_ff[MW-1:0];
   assign diff     = t_ff - prod_lo;
   assign diff_abs = diff[MW-1] ? -diff : diff;

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (step_ff)
         ST_AX_DY: begin op_a = ext(ax_ff); op_b = ext(dy_ff); end
         ST_AY_DX: begin op_a = ext(ay_ff); op_b = ext(dx_ff); end
         ST_BX_DY: begin op_a = ext(bx_ff); op_b = ext(dy_ff); end
         ST_BY_DX: begin op_a = ext(by_ff); op_b = ext(dx_ff); end
         ST_DX_DX: begin op_a = ext(dx_ff); op_b = ext(dx_ff); end
         ST_DY_DY: begin op_a = ext(dy_ff); op_b = ext(dy_ff); end
         ST_TOL: begin
            op_a = {{(MW-TOL_BITS){1'b0}}, tol};
            op_b = {{(MW-TOL_BITS){1'b0}}, tol};
         end
         ST_THR: begin op_a = prod_lo; op_b = len2_ff; end
         ST_MC: begin op_a = mc_ff; op_b = mc_ff; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= ST_AX_DY;
         res_ff  <= '0;
      end else begin
         res_ff.done <= !start && busy_ff && (step_ff == ST_CMP);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= ST_AX_DY;
            dx_ff <= sub_pt(pts[6], pts[0]);
            dy_ff <= sub_pt(pts[7], pts[1]);
            ax_ff <= sub_pt(pts[2], pts[0]);
            ay_ff <= sub_pt(pts[3], pts[1]);
            bx_ff <= sub_pt(pts[4], pts[0]);
            by_ff <= sub_pt(pts[5], pts[1]);
         end else if (busy_ff) begin
            step_ff <= step_type'(step_ff + 4'd1);
            // product register holds the result issued in the step before
            case (step_ff)
               ST_AY_DX, ST_DY_DY: t_ff <= prod_lo;
               ST_BX_DY: mc_ff <= diff_abs;
               ST_BY_DX: t_ff <= prod_lo;
               ST_DX_DX: begin
                  if (diff_abs > mc_ff) mc_ff <= diff_abs;
               end
               ST_TOL: len2_ff <= t_ff + prod_lo;
               ST_MC: thr_ff <= prod_ff;
               ST_CMP: begin
                  res_ff.flat <= prod_ff <= thr_ff;
                  busy_ff     <= 1'b0;
               end
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/bcf_split.sv */
// de casteljau split at t=0.5 with floor-halving midpoints
// no dependencies
`default_nettype none
module bcf_split #(
   parameter int COORD_BITS = 13
) (
   input  wire logic [7:0][COORD_BITS-1:0] pts,
   output logic [7:0][COORD_BITS-1:0]      first,
   output logic [7:0][COORD_BITS-1:0]      second
);
   function automatic logic [COORD_BITS-1:0] half(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
      logic signed [COORD_BITS:0] s;
      s = $signed({a[COORD_BITS-1], a}) + $signed({b[COORD_BITS-1], b});
      return s[COORD_BITS:1];
   endfunction

   always_comb begin
      logic [COORD_BITS-1:0] m01, m12, m23, m012, m123, mid;
      first  = '0;
      second = '0;
      for (int k = 0; k < 2; k++) begin
         m01  = half(pts[k], pts[2+k]);
         m12  = half(pts[2+k], pts[4+k]);
         m23  = half(pts[4+k], pts[6+k]);
         m012 = half(m01, m12);
         m123 = half(m12, m23);
         mid  = half(m012, m123);
         first[k]    = pts[k];
         first[2+k]  = m01;
         first[4+k]  = m012;
         first[6+k]  = mid;
         second[k]   = mid;
         second[2+k] = m123;
         second[4+k] = m23;
         second[6+k] = pts[6+k];
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/cubic_bezier_flattener_unit.sv */
// cubic bezier flattener top: registers, cull, piece stack and sequencer
// depends on bcf_pkg, bcf_req_if, bcf_rsp_if, bcf_flat, bcf_split and the macros header
// an accepted curve passes through the cull; each piece is fetched and, below the depth limit,
// put through a flatness test (nine products through one multiplier), then emitted if flat
// or split in two if not; a piece at the limit is emitted without a test; the emit waits
// while the output is stalled; one curve at a time
// synchronous active-high reset returns control and configuration registers to their defaults
`default_nettype none
`include "cubic_bezier_flattener_unit_macros.svh"
module cubic_bezier_flattener_unit
   import bcf_pkg::*;
#(
   parameter int DEPTH_LIMIT = 6,
   parameter int COORD_BITS  = 13
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   bcf_req_if.sink                       req_chan,
   bcf_rsp_if.source                     rsp_chan,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);
   localparam int CB    = COORD_BITS;
   localparam int EW    = CB + 2;
   localparam int SLOTS = DEPTH_LIMIT + 1;
   localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int LW    = $clog2(DEPTH_LIMIT + 1);

   typedef enum logic [2:0] {S_IDLE, S_CULL, S_POP, S_TEST, S_WAIT, S_EMIT} state_type;

   state_type state_ff;
   logic [TOL_BITS-1:0]   tol_ff;
   logic signed [CB-1:0]  clip_l_ff, clip_t_ff, clip_r_ff, clip_b_ff;
   logic [7:0][CB-1:0]    cur_ff, work_ff;
   logic [LW-1:0]         work_lv_ff;
   logic [7:0][CB-1:0]    pend_pt_ff [SLOTS];
   logic [LW-1:0]         pend_lv_ff [SLOTS];
   logic [CW-1:0]         cnt_ff;
   logic [7:0]            stroke_ff, opacity_ff;
   logic [15:0]           paint_ff;
   logic                  out_valid_ff;
   logic [7:0][CB-1:0]    split_first, split_second;
   logic                  flat_start;
   bcf_flat_res_type      flat_res;
   logic                  csr_wr;
   logic signed [EW-1:0]  minx, maxx, miny, maxy, sw;
   logic                  culled;
   logic                  at_limit;
   logic                  can_push;
   logic                  out_free;

   function automatic logic signed [EW-1:0] sx(input logic [CB-1:0] v);
      return {{(EW-CB){v[CB-1]}}, v};
   endfunction

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      prdata = '0;
      unique case (paddr[4:2])
         REG_FLAT_TOL:    prdata = {{(CSR_DATA_BITS-TOL_BITS){1'b0}}, tol_ff};
         REG_CLIP_LEFT:   prdata = {{(CSR_DATA_BITS-CB){clip_l_ff[CB-1]}}, clip_l_ff};
         REG_CLIP_TOP:    prdata = {{(CSR_DATA_BITS-CB){clip_t_ff[CB-1]}}, clip_t_ff};
         REG_CLIP_RIGHT:  prdata = {{(CSR_DATA_BITS-CB){clip_r_ff[CB-1]}}, clip_r_ff};
         REG_CLIP_BOTTOM: prdata = {{(CSR_DATA_BITS-CB){clip_b_ff[CB-1]}}, clip_b_ff};
         default:         prdata = '0;
      endcase
   end

   // bounding box of the four points, grown by the stroke, and the cull test against the clip window
   always_comb begin
      minx = sx(cur_ff[0]);
      maxx = sx(cur_ff[0]);
      miny = sx(cur_ff[1]);
      maxy = sx(cur_ff[1]);
      for (int k = 1; k < 4; k++) begin
         if (sx(cur_ff[2*k]) < minx) minx = sx(cur_ff[2*k]);
         if (sx(cur_ff[2*k]) > maxx) maxx = sx(cur_ff[2*k]);
         if (sx(cur_ff[2*k+1]) < miny) miny = sx(cur_ff[2*k+1]);
         if (sx(cur_ff[2*k+1]) > maxy) maxy = sx(cur_ff[2*k+1]);
      end
      sw = {{(EW-8){1'b0}}, stroke_ff};
      culled = (clip_l_ff > clip_r_ff) || (clip_t_ff > clip_b_ff)
            || (minx - sw > sx(clip_r_ff)) || (maxx + sw < sx(clip_l_ff))
            || (miny - sw > sx(clip_b_ff)) || (maxy + sw < sx(clip_t_ff));
   end

   assign at_limit   = work_lv_ff >= LW'(DEPTH_LIMIT);
   assign can_push   = ({1'b0, cnt_ff} + (CW+1)'(2)) <= (CW+1)'(SLOTS);
   assign flat_start = (state_ff == S_TEST) && !at_limit;
   assign out_free   = !out_valid_ff || rsp_chan.ready;

   bcf_flat #(.COORD_BITS(CB)) u_flat (
      .clock  (clock),
      .reset  (reset),
      .start  (flat_start),
      .tol    (tol_ff),
      .pts    (work_ff),
      .res_ff (flat_res)
   );

   bcf_split #(.COORD_BITS(CB)) u_split (
      .pts    (work_ff),
      .first  (split_first),
      .second (split_second)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         tol_ff       <= TOL_BITS'(TOL_RESET);
         clip_l_ff    <= CB'(CLIP_LO_RESET);
         clip_t_ff    <= CB'(CLIP_LO_RESET);
         clip_r_ff    <= CB'(CLIP_HI_RESET);
         clip_b_ff    <= CB'(CLIP_HI_RESET);
         stroke_ff    <= '0;
         paint_ff     <= '0;
         opacity_ff   <= '0;
      end else begin
         if (csr_wr) begin
            unique case (paddr[4:2])
               REG_FLAT_TOL:    tol_ff    <= pwdata[TOL_BITS-1:0];
               REG_CLIP_LEFT:   clip_l_ff <= pwdata[CB-1:0];
               REG_CLIP_TOP:    clip_t_ff <= pwdata[CB-1:0];
               REG_CLIP_RIGHT:  clip_r_ff <= pwdata[CB-1:0];
               REG_CLIP_BOTTOM: clip_b_ff <= pwdata[CB-1:0];
               default: ;
            endcase
         end
         out_valid_ff <= ((state_ff == S_EMIT) && out_free)
                      || (out_valid_ff && !rsp_chan.ready);

         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  cur_ff[0] <= req_chan.start_x;
                  cur_ff[1] <= req_chan.start_y;
                  cur_ff[2] <= req_chan.ctrl_a_x;
                  cur_ff[3] <= req_chan.ctrl_a_y;
                  cur_ff[4] <= req_chan.ctrl_b_x;
                  cur_ff[5] <= req_chan.ctrl_b_y;
                  cur_ff[6] <= req_chan.finish_x;
                  cur_ff[7] <= req_chan.finish_y;
                  stroke_ff  <= req_chan.stroke;
                  paint_ff   <= req_chan.paint;
                  opacity_ff <= req_chan.opacity;
                  state_ff   <= S_CULL;
               end
            end
            S_CULL: begin
               if (culled) begin
                  state_ff <= S_IDLE;
               end else begin
                  pend_pt_ff[0] <= cur_ff;
                  pend_lv_ff[0] <= '0;
                  cnt_ff        <= CW'(1);
                  state_ff      <= S_POP;
               end
            end
            S_POP: begin
               work_ff    <= pend_pt_ff[IW'(cnt_ff - CW'(1))];
               work_lv_ff <= pend_lv_ff[IW'(cnt_ff - CW'(1))];
               cnt_ff     <= cnt_ff - CW'(1);
               state_ff   <= S_TEST;
            end
            S_TEST: begin
               state_ff <= at_limit ? S_EMIT : S_WAIT;
            end
            S_WAIT: begin
               if (flat_res.done) begin
                  if (flat_res.flat) begin
                     state_ff <= S_EMIT;
                  end else if (can_push) begin
                     // second half below, first half on top
                     pend_pt_ff[cnt_ff[IW-1:0]]          <= split_second;
                     pend_lv_ff[cnt_ff[IW-1:0]]          <= work_lv_ff + LW'(1);
                     pend_pt_ff[IW'(cnt_ff + CW'(1))]    <= split_first;
                     pend_lv_ff[IW'(cnt_ff + CW'(1))]    <= work_lv_ff + LW'(1);
                     cnt_ff   <= cnt_ff + CW'(2);
                     state_ff <= S_POP;
                  end else begin
                     state_ff <= (cnt_ff == '0) ? S_IDLE : S_POP;
                  end
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_chan.seg_start_x       <= work_ff[0];
                  rsp_chan.seg_start_y       <= work_ff[1];
                  rsp_chan.seg_end_x         <= work_ff[6];
                  rsp_chan.seg_end_y         <= work_ff[7];
                  rsp_chan.seg_stroke        <= stroke_ff;
                  rsp_chan.seg_paint         <= paint_ff;
                  rsp_chan.seg_opacity       <= opacity_ff;
                  rsp_chan.high_quality      <= stroke_ff > 8'd1;
                  rsp_chan.last_segment      <= cnt_ff == '0;
                  state_ff <= (cnt_ff == '0) ? S_IDLE : S_POP;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BCF_ASSERT_IMPL(a_hq_follows_stroke, clock, reset, rsp_chan.valid, rsp_chan.high_quality == (rsp_chan.seg_stroke > 8'd1))
   `BCF_ASSERT_IMPL(a_stack_bound, clock, reset, 1'b1, cnt_ff <= CW'(SLOTS))
   `BCF_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
endmodule
`default_nettype wire
